// File: src/cp_pkg.sv
// ============================================================================
// cp_pkg: shared types, constants and table functions
// Holds the transaction structs, pipeline depths and the arctangent table of
// the rectangular-to-polar converter.
// ============================================================================
package cp_pkg;

    // Width of each input coordinate and of the magnitude
    localparam int COORD_WIDTH = 16;
    // Width of the phase result (13 fraction bits)
    localparam int PHASE_W = 16;
    // Number of rotation steps
    localparam int ANG_STEPS = 62;
    // Width of the rotation datapath and angle accumulator
    localparam int ACC_W = 64;
    // Bit that the larger coordinate is normalised to
    localparam int NORM_MSB = 60;
    // Angle fraction bits dropped by the final rounding
    localparam int ROUND_LSB = NORM_MSB - 13;
    localparam int SHIFT_W = $clog2(NORM_MSB + 1);
    localparam int POS_W = $clog2(COORD_WIDTH);
    // Phase code of +pi
    localparam int PHASE_PI = 25736;

    // Pipeline depths, in register stages
    localparam int FRONT_STAGES = 3;
    localparam int BACK_STAGES = 3;
    localparam int LATENCY = FRONT_STAGES + ANG_STEPS + BACK_STAGES;
    // Alignment stages after the square-root pipeline
    localparam int MAG_DELAY = LATENCY - 3 - COORD_WIDTH;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] real_part;
        logic signed [COORD_WIDTH-1:0] imag_part;
    } cp_in_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0]    magnitude;
        logic signed [PHASE_W-1:0] phase;
    } cp_out_t;

    // Quadrant and axis information that travels beside the rotation
    typedef struct packed {
        logic re_neg;
        logic im_neg;
        logic x_zero;
        logic y_zero;
    } cp_flags_t;

    // Restoring long division, used only while building constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(1/n) scaled by 2^62, from the alternating power series
    function automatic logic [63:0] atan_inv_scaled(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] k;
        p   = udiv64(64'h4000_0000_0000_0000, n);
        pos = '0;
        neg = '0;
        k   = '0;
        while (p != '0)
        begin
            term = udiv64(p, {k[62:0], 1'b1});
            if (!k[0])
            begin
                pos = pos + term;
            end
            else
            begin
                neg = neg + term;
            end
            p = udiv64(udiv64(p, n), n);
            k = k + 64'd1;
        end
        return pos - neg;
    endfunction

    // pi at 60 fraction bits (pi/4 at 62 fraction bits)
    function automatic logic [63:0] pi_fx60();
        return atan_inv_scaled(64'd2) + atan_inv_scaled(64'd3);
    endfunction

    // atan(2^-idx) at 60 fraction bits, rounded
    function automatic logic [63:0] atan_entry(input int idx);
        logic [63:0] v;
        if (idx == 0)
        begin
            v = pi_fx60();
        end
        else
        begin
            v = atan_inv_scaled(64'd1 << idx);
        end
        return (v + 64'd2) >> 2;
    endfunction

    localparam logic signed [ACC_W-1:0] PI_FX60      = $signed(pi_fx60());
    localparam logic signed [ACC_W-1:0] PI_HALF_FX60 = PI_FX60 >>> 1;

endpackage

// File: src/cp_front.sv
// ============================================================================
// cp_front: input conditioning
// Takes absolute values, finds the leading one of the larger part and
// normalises the vector so that its larger part has bit 60 as its top bit.
// ============================================================================
module cp_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  cp_pkg::cp_in_t                      operand,
    output logic [cp_pkg::COORD_WIDTH-1:0]      abs_re,
    output logic [cp_pkg::COORD_WIDTH-1:0]      abs_im,
    output logic                                norm_valid,
    output logic signed [cp_pkg::ACC_W-1:0]     norm_x,
    output logic signed [cp_pkg::ACC_W-1:0]     norm_y,
    output cp_pkg::cp_flags_t                   norm_flags
);

    // Stage 1 registers
    logic                             v1_reg;
    logic [cp_pkg::COORD_WIDTH-1:0]   are_reg, are_next;
    logic [cp_pkg::COORD_WIDTH-1:0]   aim_reg, aim_next;
    logic                             re_neg_reg;
    logic                             im_neg_reg;

    // Stage 2 registers
    logic                             v2_reg;
    logic [cp_pkg::COORD_WIDTH-1:0]   ux_reg;
    logic [cp_pkg::COORD_WIDTH-1:0]   uy_reg;
    logic [cp_pkg::SHIFT_W-1:0]       sh_reg, sh_next;
    cp_pkg::cp_flags_t                flags2_reg, flags2_next;

    // Stage 3 registers
    logic                             v3_reg;
    logic signed [cp_pkg::ACC_W-1:0]  x_reg, x_next;
    logic signed [cp_pkg::ACC_W-1:0]  y_reg, y_next;
    cp_pkg::cp_flags_t                flags3_reg;

    logic [cp_pkg::COORD_WIDTH-1:0]   max_part;
    logic [cp_pkg::POS_W-1:0]         msb_pos;

    // Take absolute values; the most negative input maps to 2^(W-1)
    always_comb
    begin
        are_next = operand.real_part[cp_pkg::COORD_WIDTH-1]
                 ? (~operand.real_part + 1'b1) : operand.real_part;
        aim_next = operand.imag_part[cp_pkg::COORD_WIDTH-1]
                 ? (~operand.imag_part + 1'b1) : operand.imag_part;
    end

    // Find the leading one of the larger part and the shift to bit 60
    always_comb
    begin
        max_part = (are_reg > aim_reg) ? are_reg : aim_reg;
        msb_pos  = '0;
        for (int b = 0; b < cp_pkg::COORD_WIDTH; b++)
        begin
            if (max_part[b])
            begin
                msb_pos = cp_pkg::POS_W'(b);
            end
        end
        sh_next = cp_pkg::SHIFT_W'(cp_pkg::NORM_MSB)
                - {{(cp_pkg::SHIFT_W - cp_pkg::POS_W){1'b0}}, msb_pos};
        flags2_next.re_neg = re_neg_reg;
        flags2_next.im_neg = im_neg_reg;
        flags2_next.x_zero = (are_reg == '0);
        flags2_next.y_zero = (aim_reg == '0);
    end

    // Shift both parts left by the same amount
    always_comb
    begin
        x_next = $signed({{(cp_pkg::ACC_W - cp_pkg::COORD_WIDTH){1'b0}}, ux_reg} << sh_reg);
        y_next = $signed({{(cp_pkg::ACC_W - cp_pkg::COORD_WIDTH){1'b0}}, uy_reg} << sh_reg);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        are_reg    <= are_next;
        aim_reg    <= aim_next;
        re_neg_reg <= operand.real_part[cp_pkg::COORD_WIDTH-1];
        im_neg_reg <= operand.imag_part[cp_pkg::COORD_WIDTH-1];
        ux_reg     <= are_reg;
        uy_reg     <= aim_reg;
        sh_reg     <= sh_next;
        flags2_reg <= flags2_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        flags3_reg <= flags2_reg;
    end

    assign abs_re     = are_reg;
    assign abs_im     = aim_reg;
    assign norm_valid = v3_reg;
    assign norm_x     = x_reg;
    assign norm_y     = y_reg;
    assign norm_flags = flags3_reg;

endmodule

// File: src/cp_cordic.sv
// ============================================================================
// cp_cordic: vectoring rotation pipeline
// One register stage per rotation step: drives y towards zero and sums the
// arctangent of each step into the angle accumulator.
// ============================================================================
module cp_cordic
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [cp_pkg::ACC_W-1:0]     in_x,
    input  logic signed [cp_pkg::ACC_W-1:0]     in_y,
    input  cp_pkg::cp_flags_t                   in_flags,
    output logic                                out_valid,
    output logic signed [cp_pkg::ACC_W-1:0]     out_z,
    output cp_pkg::cp_flags_t                   out_flags
);

    logic                             v_reg     [cp_pkg::ANG_STEPS];
    logic signed [cp_pkg::ACC_W-1:0]  x_reg     [cp_pkg::ANG_STEPS];
    logic signed [cp_pkg::ACC_W-1:0]  y_reg     [cp_pkg::ANG_STEPS];
    logic signed [cp_pkg::ACC_W-1:0]  z_reg     [cp_pkg::ANG_STEPS];
    cp_pkg::cp_flags_t                flags_reg [cp_pkg::ANG_STEPS];

    for (genvar i = 0; i < cp_pkg::ANG_STEPS; i++)
    begin : g_step
        localparam logic signed [cp_pkg::ACC_W-1:0] ATAN_I = $signed(cp_pkg::atan_entry(i));

        logic                             vi;
        logic signed [cp_pkg::ACC_W-1:0]  xi, yi, zi;
        cp_pkg::cp_flags_t                fi;
        logic signed [cp_pkg::ACC_W-1:0]  x_next, y_next, z_next;

        // Select the stage input
        if (i == 0)
        begin : g_first
            assign vi = in_valid;
            assign xi = in_x;
            assign yi = in_y;
            assign zi = '0;
            assign fi = in_flags;
        end
        else
        begin : g_rest
            assign vi = v_reg[i-1];
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign fi = flags_reg[i-1];
        end

        // Rotate towards the x axis by atan(2^-i)
        always_comb
        begin
            if (!yi[cp_pkg::ACC_W-1] && (yi != '0))
            begin
                x_next = xi + (yi >>> i);
                y_next = yi - (xi >>> i);
                z_next = zi + ATAN_I;
            end
            else
            begin
                x_next = xi - (yi >>> i);
                y_next = yi + (xi >>> i);
                z_next = zi - ATAN_I;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i]     <= x_next;
            y_reg[i]     <= y_next;
            z_reg[i]     <= z_next;
            flags_reg[i] <= fi;
        end
    end

    assign out_valid = v_reg[cp_pkg::ANG_STEPS-1];
    assign out_z     = z_reg[cp_pkg::ANG_STEPS-1];
    assign out_flags = flags_reg[cp_pkg::ANG_STEPS-1];

endmodule

// File: src/cp_back.sv
// ============================================================================
// cp_back: quadrant correction and rounding
// Resolves the axis cases, maps the first-quadrant angle to the full circle
// and rounds it to 13 fraction bits, half away from zero.
// ============================================================================
module cp_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [cp_pkg::ACC_W-1:0]     in_z,
    input  cp_pkg::cp_flags_t                   in_flags,
    output logic                                out_valid,
    output logic signed [cp_pkg::PHASE_W-1:0]   phase
);

    logic                             v1_reg, v2_reg, v3_reg;
    logic signed [cp_pkg::ACC_W-1:0]  a1_reg, a1_next;
    logic                             im_neg_reg;
    logic [cp_pkg::ACC_W-1:0]         ua_reg, ua_next;
    logic                             neg_reg;
    logic signed [cp_pkg::PHASE_W-1:0] phase_reg, phase_next;

    logic signed [cp_pkg::ACC_W-1:0]  fq;
    logic [cp_pkg::ACC_W-1:0]         rsum;
    logic [cp_pkg::PHASE_W-1:0]       q;

    // Pick the axis cases, then reflect for a negative real part
    always_comb
    begin
        if (in_flags.y_zero)
        begin
            fq = '0;
        end
        else if (in_flags.x_zero)
        begin
            fq = cp_pkg::PI_HALF_FX60;
        end
        else
        begin
            fq = in_z;
        end
        a1_next = in_flags.re_neg ? (cp_pkg::PI_FX60 - fq) : fq;
    end

    // Split into magnitude and final sign
    always_comb
    begin
        ua_next = a1_reg[cp_pkg::ACC_W-1] ? $unsigned(-a1_reg) : $unsigned(a1_reg);
    end

    // Round to 13 fraction bits and restore the sign
    always_comb
    begin
        rsum       = ua_reg + (cp_pkg::ACC_W'(1) << (cp_pkg::ROUND_LSB - 1));
        q          = rsum[cp_pkg::ROUND_LSB +: cp_pkg::PHASE_W];
        phase_next = neg_reg ? $signed(-q) : $signed(q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg     <= a1_next;
        im_neg_reg <= in_flags.im_neg;
        ua_reg     <= ua_next;
        neg_reg    <= a1_reg[cp_pkg::ACC_W-1] ^ im_neg_reg;
        phase_reg  <= phase_next;
    end

    assign out_valid = v3_reg;
    assign phase     = phase_reg;

endmodule

// File: src/cp_mag.sv
// ============================================================================
// cp_mag: exact integer magnitude
// Squares and sums the parts, takes the floor square root one result bit per
// stage, and delays the result to line up with the phase path.
// ============================================================================
module cp_mag
(
    input  logic                              clk,
    input  logic [cp_pkg::COORD_WIDTH-1:0]    abs_re,
    input  logic [cp_pkg::COORD_WIDTH-1:0]    abs_im,
    output logic [cp_pkg::COORD_WIDTH-1:0]    magnitude
);

    localparam int W     = cp_pkg::COORD_WIDTH;
    localparam int SQ_W  = 2 * W;
    localparam int REM_W = W + 2;

    logic [SQ_W-1:0]  sq_re_reg, sq_im_reg;
    logic [SQ_W-1:0]  sum_reg;

    logic [SQ_W-1:0]  rad_reg  [W];
    logic [REM_W-1:0] rem_reg  [W];
    logic [W-1:0]     root_reg [W];

    logic [W-1:0]     mdly_reg [cp_pkg::MAG_DELAY];

    // Square, then sum
    always_ff @(posedge clk)
    begin
        sq_re_reg <= abs_re * abs_re;
        sq_im_reg <= abs_im * abs_im;
        sum_reg   <= sq_re_reg + sq_im_reg;
    end

    // One root bit per stage, two radicand bits at a time
    for (genvar k = 0; k < W; k++)
    begin : g_root
        logic [SQ_W-1:0]  rad_in;
        logic [REM_W-1:0] rem_in;
        logic [W-1:0]     root_in;
        logic [REM_W+1:0] tmp;
        logic [REM_W+1:0] trial;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rad_in  = sum_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb
        begin
            tmp   = {rem_in, rad_in[SQ_W-1 -: 2]};
            trial = {2'b00, root_in, 2'b01};
            ge    = (tmp >= trial);
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= {rad_in[SQ_W-3:0], 2'b00};
            rem_reg[k]  <= ge ? REM_W'(tmp - trial) : tmp[REM_W-1:0];
            root_reg[k] <= {root_in[W-2:0], ge};
        end
    end

    // Hold the result until the phase is ready
    for (genvar d = 0; d < cp_pkg::MAG_DELAY; d++)
    begin : g_align
        if (d == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                mdly_reg[d] <= root_reg[W-1];
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                mdly_reg[d] <= mdly_reg[d-1];
            end
        end
    end

    assign magnitude = mdly_reg[cp_pkg::MAG_DELAY-1];

endmodule

// File: src/cartesian_to_polar_core.sv
// Each result marked by done passes through the front, rotation and back
// register stages in that order after the accepting edge of start.
// Throughput: one transaction per cycle; the 62-stage rotation pipeline and
// the 16-stage square-root pipeline each take one item per clock.
// busy stays low; results cannot be held off by the receiver.
// Reset clears every valid bit at once; no clearing pass is needed.
// ============================================================================
// cartesian_to_polar_core: rectangular-to-polar converter
// Returns the exact floor magnitude and the atan2 phase with 13 fraction bits
// for one complex sample per transaction.
// ============================================================================
module cartesian_to_polar_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cp_pkg::cp_in_t  operand,
    output logic            busy,
    output logic            done,
    output cp_pkg::cp_out_t result
);

    logic                                accept;
    logic [cp_pkg::COORD_WIDTH-1:0]      abs_re, abs_im;
    logic                                norm_valid;
    logic signed [cp_pkg::ACC_W-1:0]     norm_x, norm_y;
    cp_pkg::cp_flags_t                   norm_flags;
    logic                                rot_valid;
    logic signed [cp_pkg::ACC_W-1:0]     rot_z;
    cp_pkg::cp_flags_t                   rot_flags;
    logic [cp_pkg::COORD_WIDTH-1:0]      magnitude;
    logic signed [cp_pkg::PHASE_W-1:0]   phase;

    // The pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    cp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .operand    (operand),
        .abs_re     (abs_re),
        .abs_im     (abs_im),
        .norm_valid (norm_valid),
        .norm_x     (norm_x),
        .norm_y     (norm_y),
        .norm_flags (norm_flags)
    );

    cp_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_x      (norm_x),
        .in_y      (norm_y),
        .in_flags  (norm_flags),
        .out_valid (rot_valid),
        .out_z     (rot_z),
        .out_flags (rot_flags)
    );

    cp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_z      (rot_z),
        .in_flags  (rot_flags),
        .out_valid (done),
        .phase     (phase)
    );

    cp_mag u_mag
    (
        .clk       (clk),
        .abs_re    (abs_re),
        .abs_im    (abs_im),
        .magnitude (magnitude)
    );

    assign result.magnitude = magnitude;
    assign result.phase     = phase;

endmodule

// File: src/cp_checker.sv
// ============================================================================
// cp_checker: port-level checks for the converter
// Watches the top-level ports for latency, range and axis results.
// ============================================================================
module cp_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input cp_pkg::cp_in_t  operand,
    input logic            busy,
    input logic            done,
    input cp_pkg::cp_out_t result
);

    localparam int CNT_W = $clog2(cp_pkg::LATENCY + 1);

    logic [CNT_W-1:0] warm_reg, warm_next;
    logic             warm;

    // Count cycles since reset so that history checks start when valid
    always_comb
    begin
        warm_next = (warm_reg == CNT_W'(cp_pkg::LATENCY)) ? warm_reg : warm_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
        end
        else
        begin
            warm_reg <= warm_next;
        end
    end

    assign warm = (warm_reg == CNT_W'(cp_pkg::LATENCY));

    // Every transaction returns exactly one result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        warm |-> (done == $past(start && !busy, cp_pkg::LATENCY)))
        else $error("result strobe out of step with accepted transactions");

    // Phase stays within -pi .. +pi
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.phase <= 16'(cp_pkg::PHASE_PI)
                  && result.phase >= -16'(cp_pkg::PHASE_PI)))
        else $error("phase outside -pi .. +pi");

    // The origin gives zero magnitude and zero phase
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && $past(start && !busy && operand.real_part == '0
                       && operand.imag_part == '0, cp_pkg::LATENCY))
        |-> (result.magnitude == '0 && result.phase == '0))
        else $error("origin did not give a zero result");

    // The positive real axis gives zero phase and the real part as magnitude
    a_pos_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && $past(start && !busy && operand.imag_part == '0
                       && !operand.real_part[cp_pkg::COORD_WIDTH-1]
                       && operand.real_part != '0, cp_pkg::LATENCY))
        |-> (result.phase == '0
             && result.magnitude == $unsigned($past(operand.real_part, cp_pkg::LATENCY))))
        else $error("positive real axis gave a wrong result");

endmodule

bind cartesian_to_polar_core cp_checker u_cp_checker (.*);
